>>> src/tss_pkg.sv
// Shared codes, reset values and types of the trigger smash safety sequencer.
package tss_pkg;

   // Counter width default
   localparam int DEF_COUNT_BITS = 16;

   // Configuration register widths, indexes and reset values
   localparam int CFG_BITS  = 16;
   localparam int ADDR_BITS = 4;
   localparam int DATA_BITS = 32;

   localparam logic [1:0] REG_TRIGGER_DELAY  = 2'd0;
   localparam logic [1:0] REG_SMASH_PULSE    = 2'd1;
   localparam logic [1:0] REG_HB_TIMEOUT     = 2'd2;

   localparam logic [CFG_BITS-1:0] RST_TRIGGER_DELAY = 16'd100;
   localparam logic [CFG_BITS-1:0] RST_SMASH_PULSE   = 16'd50;
   localparam logic [CFG_BITS-1:0] RST_HB_TIMEOUT    = 16'd300;

   // Mode codes
   localparam logic [1:0] MODE_IDLE      = 2'd0;
   localparam logic [1:0] MODE_TRIGGERED = 2'd1;
   localparam logic [1:0] MODE_SMASHING  = 2'd2;
   localparam logic [1:0] MODE_UNUSED    = 2'd3;

   // Motor orders
   localparam logic [1:0] MOTOR_NONE  = 2'd0;
   localparam logic [1:0] MOTOR_SMASH = 2'd1;
   localparam logic [1:0] MOTOR_READY = 2'd2;

   // Event codes
   localparam logic [1:0] EVENT_NONE     = 2'd0;
   localparam logic [1:0] EVENT_FOUND    = 2'd1;
   localparam logic [1:0] EVENT_DONE     = 2'd2;

   // Trigger reasons
   localparam logic [1:0] REASON_NONE        = 2'd0;
   localparam logic [1:0] REASON_FINAL       = 2'd1;
   localparam logic [1:0] REASON_TOUCH       = 2'd2;
   localparam logic [1:0] REASON_AUTOMATIC   = 2'd3;

   // Host commands
   localparam logic [1:0] CMD_NONE   = 2'd0;
   localparam logic [1:0] CMD_SMASH  = 2'd1;
   localparam logic [1:0] CMD_CANCEL = 2'd2;
   localparam logic [1:0] CMD_OTHER  = 2'd3;

   // Sensor flags and command of one tick
   typedef struct packed {
      logic       touch_hit;
      logic       last_resort_hit;
      logic       optical_wet;
      logic       ultrasonic_wet;
      logic       tilt_good;
      logic       heartbeat_seen;
      logic [1:0] new_command;
   } tick_type;

   // Mode state kept between ticks (counters travel separately)
   typedef struct packed {
      logic [1:0] mode;
      logic       moving;
      logic [1:0] pending;
   } seq_state_type;

   // Result of one tick
   typedef struct packed {
      logic [1:0] mode;
      logic [1:0] motor_order;
      logic [1:0] event_code;
      logic [1:0] trigger_reason;
      logic       heartbeat_lost;
      logic       tilt_veto;
   } result_type;

endpackage

>>> src/trigger_smash_safety_sequencer.sv
// Top level of the trigger smash safety sequencer: state, result register and CSR port.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------------
//   req      | req_valid / req_ready | touch, last resort, wet flags, tilt, hb, command
//   rsp      | rsp_valid / rsp_ready | mode, motor order, event, reason, hb lost, veto
//   csr      | psel/penable/pwrite   | three 16-bit tick registers at 0x0, 0x4, 0x8
//
// Each item is worked in the cycle it is accepted; its result appears in the
// result register on the next cycle. One item per cycle is taken while the result
// register is empty or being drained, so a stalled rsp side holds req_ready low.
// Synchronous active-high reset clears mode, counters, pending command and rsp_valid.
// Registers come up as delay 100, pulse 50, heartbeat timeout 300 ticks.
module trigger_smash_safety_sequencer
   import tss_pkg::*;
#(
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_touch_hit,
   input  logic                 req_last_resort_hit,
   input  logic                 req_optical_wet,
   input  logic                 req_ultrasonic_wet,
   input  logic                 req_tilt_good,
   input  logic                 req_heartbeat_seen,
   input  logic [1:0]           req_new_command,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_mode,
   output logic [1:0]           rsp_motor_order,
   output logic [1:0]           rsp_event_code,
   output logic [1:0]           rsp_trigger_reason,
   output logic                 rsp_heartbeat_lost,
   output logic                 rsp_tilt_veto,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   tick_type              tick;
   seq_state_type         state_ff, state_in;
   logic [COUNT_BITS-1:0] elapsed_ff, elapsed_in;
   logic [COUNT_BITS-1:0] age_ff, age_in;
   result_type            result_in, result_ff;
   logic                  rsp_valid_ff;
   logic                  accept;
   logic                  cfg_write;
   logic [1:0]            cfg_index;
   logic [CFG_BITS-1:0]   delay_ff, pulse_ff, timeout_ff;

   // gather the item
   assign tick.touch_hit       = req_touch_hit;
   assign tick.last_resort_hit = req_last_resort_hit;
   assign tick.optical_wet     = req_optical_wet;
   assign tick.ultrasonic_wet  = req_ultrasonic_wet;
   assign tick.tilt_good       = req_tilt_good;
   assign tick.heartbeat_seen  = req_heartbeat_seen;
   assign tick.new_command     = req_new_command;

   // accept while the result register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   tss_step #(
      .COUNT_BITS (COUNT_BITS)
   ) u_step (
      .tick          (tick),
      .state_cur     (state_ff),
      .elapsed_cur   (elapsed_ff),
      .age_cur       (age_ff),
      .trigger_delay (delay_ff),
      .smash_pulse   (pulse_ff),
      .hb_timeout    (timeout_ff),
      .state_nxt     (state_in),
      .elapsed_nxt   (elapsed_in),
      .age_nxt       (age_in),
      .result        (result_in)
   );

   // advance sequencer state on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode    <= MODE_IDLE;
         state_ff.moving  <= 1'b0;
         state_ff.pending <= CMD_NONE;
         elapsed_ff       <= '0;
         age_ff           <= '0;
      end else if (accept) begin
         state_ff   <= state_in;
         elapsed_ff <= elapsed_in;
         age_ff     <= age_in;
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mode           = result_ff.mode;
   assign rsp_motor_order    = result_ff.motor_order;
   assign rsp_event_code     = result_ff.event_code;
   assign rsp_trigger_reason = result_ff.trigger_reason;
   assign rsp_heartbeat_lost = result_ff.heartbeat_lost;
   assign rsp_tilt_veto      = result_ff.tilt_veto;

   // configuration registers
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign cfg_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff   <= RST_TRIGGER_DELAY;
         pulse_ff   <= RST_SMASH_PULSE;
         timeout_ff <= RST_HB_TIMEOUT;
      end else if (cfg_write) begin
         case (cfg_index)
            REG_TRIGGER_DELAY: delay_ff   <= pwdata[CFG_BITS-1:0];
            REG_SMASH_PULSE:   pulse_ff   <= pwdata[CFG_BITS-1:0];
            REG_HB_TIMEOUT:    timeout_ff <= pwdata[CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (cfg_index)
         REG_TRIGGER_DELAY: prdata = DATA_BITS'(delay_ff);
         REG_SMASH_PULSE:   prdata = DATA_BITS'(pulse_ff);
         REG_HB_TIMEOUT:    prdata = DATA_BITS'(timeout_ff);
         default:           prdata = '0;
      endcase
   end

endmodule

>>> src/tss_step.sv
// Next-state and result logic of one control tick.
module tss_step
   import tss_pkg::*;
#(
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  tick_type                tick,
   input  seq_state_type           state_cur,
   input  logic [COUNT_BITS-1:0]   elapsed_cur,
   input  logic [COUNT_BITS-1:0]   age_cur,
   input  logic [CFG_BITS-1:0]     trigger_delay,
   input  logic [CFG_BITS-1:0]     smash_pulse,
   input  logic [CFG_BITS-1:0]     hb_timeout,
   output seq_state_type           state_nxt,
   output logic [COUNT_BITS-1:0]   elapsed_nxt,
   output logic [COUNT_BITS-1:0]   age_nxt,
   output result_type              result
);

   localparam int CMP_BITS = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   logic                  trig;
   logic [1:0]            mode;
   logic                  moving;
   logic [1:0]            pending;
   logic [COUNT_BITS-1:0] elapsed;
   logic [COUNT_BITS-1:0] age;

   assign trig = tick.touch_hit | tick.last_resort_hit
               | (tick.optical_wet & tick.ultrasonic_wet);

   always_comb begin
      mode    = state_cur.mode;
      moving  = state_cur.moving;
      pending = (tick.new_command != CMD_NONE) ? tick.new_command : state_cur.pending;
      elapsed = elapsed_cur;
      result  = '0;

      // age the heartbeat, saturating
      if (tick.heartbeat_seen) begin
         age = '0;
      end else begin
         age = (age_cur == CNT_MAX) ? CNT_MAX : age_cur + 1'b1;
      end

      // force idle on heartbeat timeout
      if (CMP_BITS'(age) > CMP_BITS'(hb_timeout)) begin
         if (mode != MODE_IDLE || moving) begin
            result.motor_order = MOTOR_READY;
         end
         mode    = MODE_IDLE;
         elapsed = '0;
         moving  = 1'b0;
         pending = CMD_NONE;
         age     = '0;
         result.heartbeat_lost = 1'b1;
      end

      // count time in an active mode
      if (mode == MODE_TRIGGERED || mode == MODE_SMASHING) begin
         elapsed = (elapsed == CNT_MAX) ? CNT_MAX : elapsed + 1'b1;
      end

      // mode rules
      case (mode)
         MODE_IDLE: begin
            if (trig) begin
               mode    = MODE_TRIGGERED;
               elapsed = '0;
               result.event_code = EVENT_FOUND;
               if (tick.last_resort_hit) begin
                  result.trigger_reason = REASON_FINAL;
               end else if (tick.touch_hit) begin
                  result.trigger_reason = REASON_TOUCH;
               end else begin
                  result.trigger_reason = REASON_AUTOMATIC;
               end
            end else if (pending == CMD_SMASH) begin
               pending = CMD_NONE;
               if (tick.tilt_good) begin
                  mode    = MODE_SMASHING;
                  elapsed = '0;
                  moving  = 1'b1;
                  result.motor_order = MOTOR_SMASH;
               end else begin
                  result.tilt_veto = 1'b1;
               end
            end
         end
         MODE_TRIGGERED: begin
            if (pending == CMD_CANCEL) begin
               mode    = MODE_IDLE;
               elapsed = '0;
               if (moving) begin
                  result.motor_order = MOTOR_READY;
                  moving = 1'b0;
               end
               pending = CMD_NONE;
            end else if (!trig) begin
               mode    = MODE_IDLE;
               elapsed = '0;
            end else if (CMP_BITS'(elapsed) >= CMP_BITS'(trigger_delay)
                         || pending == CMD_SMASH) begin
               if (tick.tilt_good) begin
                  mode    = MODE_SMASHING;
                  elapsed = '0;
                  if (!moving) begin
                     result.motor_order = MOTOR_SMASH;
                     moving = 1'b1;
                  end
               end else begin
                  result.tilt_veto = 1'b1;
               end
               pending = CMD_NONE;
            end
         end
         MODE_SMASHING: begin
            if (pending == CMD_CANCEL) begin
               mode    = MODE_IDLE;
               elapsed = '0;
               moving  = 1'b0;
               pending = CMD_NONE;
               result.motor_order = MOTOR_READY;
            end else if (CMP_BITS'(elapsed) >= CMP_BITS'(smash_pulse)) begin
               mode    = MODE_IDLE;
               elapsed = '0;
               moving  = 1'b0;
               result.motor_order = MOTOR_READY;
               result.event_code  = EVENT_DONE;
            end else if (!tick.tilt_good) begin
               mode    = MODE_IDLE;
               elapsed = '0;
               moving  = 1'b0;
               pending = CMD_NONE;
               result.motor_order = MOTOR_READY;
            end
         end
         default: begin
            // recover from the unused mode code
            mode    = MODE_IDLE;
            elapsed = '0;
            moving  = 1'b0;
            pending = CMD_NONE;
            result.motor_order = MOTOR_READY;
         end
      endcase

      result.mode       = mode;
      state_nxt.mode    = mode;
      state_nxt.moving  = moving;
      state_nxt.pending = pending;
      elapsed_nxt       = elapsed;
      age_nxt           = age;
   end

endmodule

>>> src/tss_checker.sv
// Port-level assertions for the trigger smash safety sequencer, bound to the top level.
module tss_checker
   import tss_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [1:0]           rsp_mode,
   input logic [1:0]           rsp_motor_order,
   input logic [1:0]           rsp_event_code,
   input logic [1:0]           rsp_trigger_reason,
   input logic                 rsp_heartbeat_lost,
   input logic                 rsp_tilt_veto
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode)
         && $stable(rsp_motor_order) && $stable(rsp_event_code))
      else $error("stalled result changed");

   // a reason comes only with a detected event
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code != EVENT_FOUND |-> rsp_trigger_reason == REASON_NONE)
      else $error("trigger reason without detected event");

   // a finished pulse returns idle and drives to ready
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code == EVENT_DONE
         |-> rsp_mode == MODE_IDLE && rsp_motor_order == MOTOR_READY)
      else $error("action done without return to idle");

   // a vetoed smash never moves the motor nor enters smashing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tilt_veto
         |-> rsp_motor_order == MOTOR_NONE && rsp_mode != MODE_SMASHING)
      else $error("tilt veto with motion");

   // a lost heartbeat never leaves the block smashing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_heartbeat_lost |-> rsp_mode != MODE_SMASHING
         && rsp_motor_order != MOTOR_SMASH)
      else $error("smashing after heartbeat loss");

endmodule

bind trigger_smash_safety_sequencer tss_checker u_tss_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_mode           (rsp_mode),
   .rsp_motor_order    (rsp_motor_order),
   .rsp_event_code     (rsp_event_code),
   .rsp_trigger_reason (rsp_trigger_reason),
   .rsp_heartbeat_lost (rsp_heartbeat_lost),
   .rsp_tilt_veto      (rsp_tilt_veto)
);

>>> dv/trigger_smash_safety_sequencer_check.sv
`timescale 1ns / 100ps
// Result predictor and comparator for the trigger smash safety sequencer channels.
module trigger_smash_safety_sequencer_check
   import tss_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  tick_type             req_tick,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  result_type           rsp_result,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic                 pready,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output int                   mismatches,
   output int                   results_due,
   output int                   results_seen,
   output int                   done_seen,
   output int                   lost_seen,
   output int                   veto_seen
);

   // Tick registers as last written over the CSR port
   logic [CFG_BITS-1:0] delay_ticks;
   logic [CFG_BITS-1:0] pulse_ticks;
   logic [CFG_BITS-1:0] hb_limit;

   // Sequencer state
   logic [1:0]                mode_q;
   logic                      moving;
   logic [1:0]                pend;
   logic [DEF_COUNT_BITS-1:0] elapsed;
   logic [DEF_COUNT_BITS-1:0] hb_age;

   result_type tick_results_due[$];
   int errors = 0;
   int checked = 0;
   int dones = 0;
   int losses = 0;
   int vetoes = 0;

   function automatic logic [DEF_COUNT_BITS-1:0] bump(input logic [DEF_COUNT_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // Advance the sequencer by one tick and return what it reports
   function automatic result_type run_tick(input tick_type t);
      result_type r;
      logic       trig;
      r = '0;
      trig = t.touch_hit || t.last_resort_hit || (t.optical_wet && t.ultrasonic_wet);

      // Latch a fresh command before anything else looks at it
      if (t.new_command != CMD_NONE) pend = t.new_command;

      // Age the host heartbeat; force idle once it runs past the limit
      hb_age = t.heartbeat_seen ? '0 : bump(hb_age);
      if (hb_age > hb_limit) begin
         if (mode_q != MODE_IDLE || moving) r.motor_order = MOTOR_READY;
         mode_q = MODE_IDLE;
         elapsed = '0;
         moving = 1'b0;
         pend = CMD_NONE;
         hb_age = '0;
         r.heartbeat_lost = 1'b1;
      end

      if (mode_q == MODE_TRIGGERED || mode_q == MODE_SMASHING) elapsed = bump(elapsed);

      case (mode_q)
         MODE_IDLE: begin
            if (trig) begin
               mode_q = MODE_TRIGGERED;
               elapsed = '0;
               r.event_code = EVENT_FOUND;
               r.trigger_reason = t.last_resort_hit ? REASON_FINAL :
                                  t.touch_hit       ? REASON_TOUCH : REASON_AUTOMATIC;
            end else if (pend == CMD_SMASH) begin
               pend = CMD_NONE;
               if (t.tilt_good) begin
                  mode_q = MODE_SMASHING;
                  elapsed = '0;
                  r.motor_order = MOTOR_SMASH;
                  moving = 1'b1;
               end else begin
                  r.tilt_veto = 1'b1;
               end
            end
         end
         MODE_TRIGGERED: begin
            if (pend == CMD_CANCEL) begin
               mode_q = MODE_IDLE;
               elapsed = '0;
               if (moving) begin
                  r.motor_order = MOTOR_READY;
                  moving = 1'b0;
               end
               pend = CMD_NONE;
            end else if (!trig) begin
               // trigger gone: drop back, keep the command waiting
               mode_q = MODE_IDLE;
               elapsed = '0;
            end else if (elapsed >= delay_ticks || pend == CMD_SMASH) begin
               if (t.tilt_good) begin
                  mode_q = MODE_SMASHING;
                  elapsed = '0;
                  if (!moving) begin
                     r.motor_order = MOTOR_SMASH;
                     moving = 1'b1;
                  end
               end else begin
                  r.tilt_veto = 1'b1;
               end
               pend = CMD_NONE;
            end
         end
         MODE_SMASHING: begin
            // cancel, end of pulse and tilt loss all retract the drive
            if (pend == CMD_CANCEL || elapsed >= pulse_ticks || !t.tilt_good) begin
               if (pend != CMD_CANCEL && elapsed >= pulse_ticks) r.event_code = EVENT_DONE;
               else pend = CMD_NONE;
               mode_q = MODE_IDLE;
               elapsed = '0;
               r.motor_order = MOTOR_READY;
               moving = 1'b0;
            end
         end
         default: begin
            mode_q = MODE_IDLE;
            elapsed = '0;
            r.motor_order = MOTOR_READY;
            moving = 1'b0;
            pend = CMD_NONE;
         end
      endcase

      r.mode = mode_q;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [1:0] want,
                                input logic [1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      result_type fresh;
      if (reset) begin
         delay_ticks = RST_TRIGGER_DELAY;
         pulse_ticks = RST_SMASH_PULSE;
         hb_limit    = RST_HB_TIMEOUT;
         mode_q  = MODE_IDLE;
         moving  = 1'b0;
         pend    = CMD_NONE;
         elapsed = '0;
         hb_age  = '0;
         tick_results_due.delete();
      end else begin
         // Compare an accepted result with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (tick_results_due.size() == 0) begin
               $display("%0t: result with none due, actual %b", $time, rsp_result);
               errors++;
            end else begin
               want = tick_results_due.pop_front();
               compare_field("mode", want.mode, rsp_result.mode);
               compare_field("motor_order", want.motor_order, rsp_result.motor_order);
               compare_field("event_code", want.event_code, rsp_result.event_code);
               compare_field("trigger_reason", want.trigger_reason,
                             rsp_result.trigger_reason);
               compare_field("heartbeat_lost", want.heartbeat_lost,
                             rsp_result.heartbeat_lost);
               compare_field("tilt_veto", want.tilt_veto, rsp_result.tilt_veto);
               checked++;
            end
         end

         // Track register writes
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_TRIGGER_DELAY: delay_ticks = pwdata[CFG_BITS-1:0];
               REG_SMASH_PULSE:   pulse_ticks = pwdata[CFG_BITS-1:0];
               REG_HB_TIMEOUT:    hb_limit    = pwdata[CFG_BITS-1:0];
               default: ;
            endcase
         end

         // Predict the result of an accepted item
         if (req_valid && req_ready) begin
            fresh = run_tick(req_tick);
            if (fresh.event_code == EVENT_DONE) dones++;
            if (fresh.heartbeat_lost) losses++;
            if (fresh.tilt_veto) vetoes++;
            tick_results_due.push_back(fresh);
         end
      end
      results_due  <= tick_results_due.size();
      mismatches   <= errors;
      results_seen <= checked;
      done_seen    <= dones;
      lost_seen    <= losses;
      veto_seen    <= vetoes;
   end

endmodule

>>> dv/trigger_smash_safety_sequencer_test.sv
`timescale 1ns / 100ps
// Stimulus, register settings and verdict for the trigger smash safety sequencer.
module trigger_smash_safety_sequencer_test;
   import tss_pkg::*;

   typedef enum int {RUN_TRIGGER, RUN_COMMAND, RUN_STARVE, RUN_NOISE} run_kind_type;

   localparam int PHASES      = 9;
   localparam int PHASE_TICKS = 104;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   tick_type             req_tick = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_mode;
   logic [1:0]           rsp_motor_order;
   logic [1:0]           rsp_event_code;
   logic [1:0]           rsp_trigger_reason;
   logic                 rsp_heartbeat_lost;
   logic                 rsp_tilt_veto;
   result_type           rsp_result;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [ADDR_BITS-1:0] paddr = '0;
   logic [DATA_BITS-1:0] pwdata = '0;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;

   int mismatches, results_due, results_seen, done_seen, lost_seen, veto_seen;
   int ticks_sent = 0;
   int settings_used = 1;
   bit sender_calm = 1'b0;
   bit receiver_calm = 1'b0;

   assign rsp_result = {rsp_mode, rsp_motor_order, rsp_event_code, rsp_trigger_reason,
                        rsp_heartbeat_lost, rsp_tilt_veto};

   trigger_smash_safety_sequencer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_touch_hit       (req_tick.touch_hit),
      .req_last_resort_hit (req_tick.last_resort_hit),
      .req_optical_wet     (req_tick.optical_wet),
      .req_ultrasonic_wet  (req_tick.ultrasonic_wet),
      .req_tilt_good       (req_tick.tilt_good),
      .req_heartbeat_seen  (req_tick.heartbeat_seen),
      .req_new_command     (req_tick.new_command),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_mode            (rsp_mode),
      .rsp_motor_order     (rsp_motor_order),
      .rsp_event_code      (rsp_event_code),
      .rsp_trigger_reason  (rsp_trigger_reason),
      .rsp_heartbeat_lost  (rsp_heartbeat_lost),
      .rsp_tilt_veto       (rsp_tilt_veto),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   trigger_smash_safety_sequencer_check judge (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_tick     (req_tick),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_result   (rsp_result),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .pready       (pready),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .mismatches   (mismatches),
      .results_due  (results_due),
      .results_seen (results_seen),
      .done_seen    (done_seen),
      .lost_seen    (lost_seen),
      .veto_seen    (veto_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop if the run hangs
   initial begin
      #3_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic bit chance(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic tick_type make_tick(input bit touch, input bit last_resort,
                                          input bit optical, input bit ultrasonic,
                                          input bit tilt, input bit heartbeat,
                                          input logic [1:0] command);
      return {touch, last_resort, optical, ultrasonic, tilt, heartbeat, command};
   endfunction

   function automatic logic [1:0] pick_command(input int smash_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < smash_pct) return CMD_SMASH;
      if (r < smash_pct + 5) return CMD_CANCEL;
      if (r < smash_pct + 8) return CMD_OTHER;
      return CMD_NONE;
   endfunction

   // Shape one tick after the kind of run it belongs to
   function automatic tick_type draw_tick(input run_kind_type kind);
      tick_type t;
      t = 8'($urandom);
      case (kind)
         RUN_TRIGGER: begin
            if (chance(95)) begin
               case ($urandom_range(0, 2))
                  0: t.touch_hit = 1'b1;
                  1: t.last_resort_hit = 1'b1;
                  default: begin
                     t.optical_wet = 1'b1;
                     t.ultrasonic_wet = 1'b1;
                  end
               endcase
            end
            t.tilt_good = chance(92);
            t.heartbeat_seen = chance(92);
            t.new_command = pick_command(4);
         end
         RUN_COMMAND: begin
            t.touch_hit = chance(5);
            t.last_resort_hit = chance(5);
            if (t.optical_wet && chance(90)) t.ultrasonic_wet = 1'b0;
            t.tilt_good = chance(85);
            t.heartbeat_seen = chance(95);
            t.new_command = pick_command(25);
         end
         RUN_STARVE: begin
            t.heartbeat_seen = 1'b0;
            t.tilt_good = chance(80);
            t.new_command = pick_command(5);
         end
         default: ;
      endcase
      return t;
   endfunction

   // Offer one item after a random gap and hold it until taken
   task automatic send_tick(input tick_type t);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_tick <= t;
      @(posedge clock iff req_ready);
      ticks_sent++;
   endtask

   // Hold off the sender until every result has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock iff (results_due == 0));
   endtask

   // Write all three tick registers, back to back
   task automatic load_settings(input logic [CFG_BITS-1:0] delay,
                                input logic [CFG_BITS-1:0] pulse,
                                input logic [CFG_BITS-1:0] timeout);
      logic [1:0]          index[3];
      logic [CFG_BITS-1:0] value[3];
      index = '{REG_TRIGGER_DELAY, REG_SMASH_PULSE, REG_HB_TIMEOUT};
      value = '{delay, pulse, timeout};
      for (int i = 0; i < 3; i++) begin
         psel <= 1'b1;
         penable <= 1'b0;
         pwrite <= 1'b1;
         paddr <= {index[i], 2'b00};
         pwdata <= DATA_BITS'(value[i]);
         @(posedge clock);
         penable <= 1'b1;
         @(posedge clock iff pready);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      settings_used++;
   endtask

   // Drain results with random stalls
   initial begin : result_sink
      int stall;
      forever begin
         stall = receiver_calm ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock iff rsp_valid);
      end
   end

   initial begin : stimulus
      run_kind_type kind;
      int           run_left;
      int           sent_here;
      int           r;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Field extremes and each trigger reason under the reset settings
      send_tick(make_tick(0, 0, 0, 0, 0, 0, CMD_NONE));
      send_tick(make_tick(1, 1, 1, 1, 1, 1, CMD_OTHER));
      send_tick(make_tick(0, 0, 0, 0, 1, 1, CMD_NONE));
      // cancel waits in idle, then ends the trigger it meets
      send_tick(make_tick(1, 0, 0, 0, 1, 1, CMD_CANCEL));
      send_tick(make_tick(1, 0, 0, 0, 1, 1, CMD_NONE));
      send_tick(make_tick(0, 0, 1, 1, 1, 1, CMD_NONE));
      send_tick(make_tick(0, 0, 1, 0, 1, 1, CMD_NONE));
      send_tick(make_tick(0, 0, 0, 1, 1, 1, CMD_NONE));
      // smash command from idle: refused on bad tilt, then taken
      send_tick(make_tick(0, 0, 0, 0, 0, 1, CMD_SMASH));
      send_tick(make_tick(0, 0, 0, 0, 1, 1, CMD_SMASH));
      send_tick(make_tick(0, 0, 0, 0, 1, 1, CMD_CANCEL));
      send_tick(make_tick(0, 0, 0, 0, 1, 1, CMD_SMASH));
      // tilt loss while smashing
      send_tick(make_tick(0, 0, 0, 0, 0, 1, CMD_NONE));
      // smash command while triggered, vetoed then accepted
      send_tick(make_tick(1, 0, 0, 0, 1, 1, CMD_NONE));
      send_tick(make_tick(1, 0, 0, 0, 0, 1, CMD_SMASH));
      send_tick(make_tick(1, 0, 0, 0, 1, 1, CMD_SMASH));
      send_tick(make_tick(1, 1, 0, 0, 1, 1, CMD_CANCEL));
      settle();

      // Short delays: automatic smash, pulse end, delay veto, heartbeat loss
      load_settings(16'd2, 16'd1, 16'd3);
      send_tick(make_tick(0, 1, 0, 0, 1, 1, CMD_NONE));
      send_tick(make_tick(0, 1, 0, 0, 1, 1, CMD_NONE));
      send_tick(make_tick(0, 1, 0, 0, 1, 1, CMD_NONE));
      send_tick(make_tick(0, 0, 0, 0, 1, 1, CMD_NONE));
      send_tick(make_tick(1, 0, 0, 0, 1, 0, CMD_NONE));
      repeat (3) send_tick(make_tick(1, 0, 0, 0, 0, 0, CMD_NONE));
      settle();

      // Random runs across a spread of register settings
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: load_settings(16'd0, 16'd0, 16'd0);
            1: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: load_settings(16'd3, 16'd4, 16'd12);
            3: load_settings(16'd1, 16'd2, 16'd6);
            4: load_settings(16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                             16'($urandom_range(2, 40)));
            5: load_settings(16'd5, 16'd0, 16'hFFFF);
            6: load_settings(16'd0, 16'hFFFF, 16'd3);
            7: load_settings(RST_TRIGGER_DELAY, RST_SMASH_PULSE, RST_HB_TIMEOUT);
            default: load_settings(16'($urandom), 16'($urandom), 16'($urandom));
         endcase
         receiver_calm = chance(25);
         sent_here = 0;
         while (sent_here < PHASE_TICKS) begin
            r = $urandom_range(0, 99);
            kind = (r < 40) ? RUN_TRIGGER : (r < 65) ? RUN_COMMAND :
                   (r < 80) ? RUN_STARVE : RUN_NOISE;
            run_left = $urandom_range(1, 20);
            sender_calm = chance(20);
            while (run_left > 0 && sent_here < PHASE_TICKS) begin
               send_tick(draw_tick(kind));
               run_left--;
               sent_here++;
            end
            if (chance(3)) settle();
         end
         settle();
      end

      repeat (4) @(posedge clock);
      $display("Ran %0d ticks under %0d register settings, %0d results compared.",
               ticks_sent, settings_used, results_seen);
      $display("Seen: %0d finished smash pulses, %0d heartbeat losses, %0d tilt vetoes.",
               done_seen, lost_seen, veto_seen);
      if (mismatches == 0 && results_due == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
src/tss_pkg.sv
src/tss_step.sv
src/trigger_smash_safety_sequencer.sv
src/tss_checker.sv
dv/trigger_smash_safety_sequencer_check.sv
dv/trigger_smash_safety_sequencer_test.sv
